// ===== sv/bpr_pkg.sv =====
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared types, codes and sizes for the byte pipe ring buffer.
// ----------------------------------------------------------------------------
package bpr_pkg;

    // Ring store size and derived widths
    localparam int RING_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int FILL_W     = 13;
    localparam int BYTE_W     = 8;

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_WRITE       = 2'd0,
        ACT_READ        = 2'd1,
        ACT_CLOSE_READ  = 2'd2,
        ACT_CLOSE_WRITE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_WAIT   = 3'd1,
        ST_AGAIN  = 3'd2,
        ST_INTR   = 3'd3,
        ST_EOF    = 3'd4,
        ST_BROKEN = 3'd5
    } status_t;

    // What the back end does with the ring store for one transaction
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   data;
        status_t             status;
        logic [FILL_W-1:0]   fill;
    } bpr_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } bpr_qstat_t;

endpackage

// ===== sv/byte_pipe_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// byte_pipe_ring_buffer
// Byte pipe on a 4096-entry ring store: write, read, close read end, close
// write end, one operation per transaction, one result per transaction.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ----------------------------------------
//  in       in_valid / in_stall  action[1:0], data_in[7:0], caller_killed
//  out      out_valid/out_stall  data_out[7:0], status[2:0], fill_level[12:0]
//  cfg      cfg_wr_en            cfg_wr_data (nonblocking)
//
//  One transaction per cycle sustained while in_stall is low. A result passes
//  through the queue entry, written at the accept edge, and then the RAM read
//  register and the result register, which the pop loads together.
//  The front decides status and pointers at accept, so throughput is set by
//  its pointer/count update; the back needs one RAM port pair.
//  Reset clears pointers, count, end states, the queue and nonblocking; the
//  ring store is not cleared and needs no clearing pass.
//  in_stall rises only when the 4-entry queue is full; out_stall backs the
//  queue up while the front keeps accepting into free slots.
//
// ----------------------------------------------------------------------------
module byte_pipe_ring_buffer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic [bpr_pkg::BYTE_W-1:0]   data_in,
    input  logic                         caller_killed,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bpr_pkg::BYTE_W-1:0]   data_out,
    output logic [2:0]                   status,
    output logic [bpr_pkg::FILL_W-1:0]   fill_level
);
    import bpr_pkg::*;

    logic       push;
    logic       pop;
    bpr_op_t    push_op;
    bpr_op_t    head_op;
    bpr_qstat_t qstat;

    // Front: classify and commit state at accept
    bpr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .data_in       (data_in),
        .caller_killed (caller_killed),
        .push          (push),
        .push_op       (push_op),
        .qstat         (qstat)
    );

    // Decoupling queue
    bpr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .qstat   (qstat)
    );

    // Back: ring store access in order, result register
    bpr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_op    (head_op),
        .qstat      (qstat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_out   (data_out),
        .status     (status),
        .fill_level (fill_level)
    );

endmodule

// ===== sv/bpr_ram.sv =====
// ----------------------------------------------------------------------------
// bpr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/bpr_front.sv =====
// ----------------------------------------------------------------------------
// bpr_front
// Accepts byte operations, decides their status and fill level, tracks
// pointers and end states, and hands store work to the queue.
// ----------------------------------------------------------------------------
module bpr_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic [bpr_pkg::BYTE_W-1:0]   data_in,
    input  logic                         caller_killed,
    output logic                         push,
    output bpr_pkg::bpr_op_t             push_op,
    input  bpr_pkg::bpr_qstat_t          qstat
);
    import bpr_pkg::*;

    logic              nonblocking_reg;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              reader_open_reg, reader_open_next;
    logic              writer_open_reg, writer_open_next;

    logic              accept;
    logic [CNT_W:0]    slot_sum;
    logic [CNT_W:0]    slot_wrap;
    status_t           refusal;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !qstat.full;
    assign push     = accept;

    assign refusal = nonblocking_reg ? ST_AGAIN : (caller_killed ? ST_INTR : ST_WAIT);

    // Tail slot = head + count, wrapped once (sum stays below twice the depth)
    assign slot_sum  = (CNT_W+1)'(rd_ptr_reg) + {1'b0, count_reg};
    assign slot_wrap = (slot_sum >= (CNT_W+1)'(RING_DEPTH))
                       ? slot_sum - (CNT_W+1)'(RING_DEPTH) : slot_sum;

    always_comb
    begin
        rd_ptr_next      = rd_ptr_reg;
        count_next       = count_reg;
        reader_open_next = reader_open_reg;
        writer_open_next = writer_open_reg;
        push_op.kind     = KIND_NONE;
        push_op.addr     = rd_ptr_reg;
        push_op.data     = data_in;
        push_op.status   = ST_OK;
        case (action)
            ACT_WRITE:
            begin
                push_op.addr = ADDR_W'(slot_wrap);
                if (!reader_open_reg)
                begin
                    push_op.status = ST_BROKEN;
                end
                else if (count_reg >= CNT_W'(RING_DEPTH))
                begin
                    push_op.status = refusal;
                end
                else
                begin
                    push_op.kind = KIND_WRITE;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            ACT_READ:
            begin
                if (count_reg == '0)
                begin
                    push_op.status = writer_open_reg ? refusal : ST_EOF;
                end
                else
                begin
                    push_op.kind = KIND_READ;
                    rd_ptr_next  = (rd_ptr_reg == ADDR_W'(RING_DEPTH - 1))
                                   ? '0 : rd_ptr_reg + ADDR_W'(1);
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            ACT_CLOSE_READ:
            begin
                reader_open_next = 1'b0;
            end
            ACT_CLOSE_WRITE:
            begin
                writer_open_next = 1'b0;
            end
            default:
            begin
                push_op.kind = KIND_NONE;
            end
        endcase
        push_op.fill = FILL_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonblocking_reg <= 1'b0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
            reader_open_reg <= 1'b1;
            writer_open_reg <= 1'b1;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                nonblocking_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                rd_ptr_reg      <= rd_ptr_next;
                count_reg       <= count_next;
                reader_open_reg <= reader_open_next;
                writer_open_reg <= writer_open_next;
            end
        end
    end

    // A closed end never reopens
    a_reader_stays_closed: assert property (@(posedge clk) disable iff (!rst_n)
        !reader_open_reg |=> !reader_open_reg)
        else $error("read end reopened");

    a_writer_stays_closed: assert property (@(posedge clk) disable iff (!rst_n)
        !writer_open_reg |=> !writer_open_reg)
        else $error("write end reopened");

    // Held byte count never exceeds the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RING_DEPTH))
        else $error("byte count above ring depth");

endmodule

// ===== sv/bpr_queue.sv =====
// ----------------------------------------------------------------------------
// bpr_queue
// Short register queue of decoded operations between front and back.
// ----------------------------------------------------------------------------
module bpr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  bpr_pkg::bpr_op_t     push_op,
    input  logic                 pop,
    output bpr_pkg::bpr_op_t     head_op,
    output bpr_pkg::bpr_qstat_t  qstat
);
    import bpr_pkg::*;

    bpr_op_t           entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QLVL_W-1:0] level_reg, level_next;

    assign qstat.full  = (level_reg == QLVL_W'(QUEUE_DEPTH));
    assign qstat.empty = (level_reg == '0);
    assign head_op     = entry[rd_ptr_reg];

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + QLVL_W'(1);
        end
        else if (pop && !push)
        begin
            level_next = level_reg - QLVL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + QPTR_W'(1);
            end
            level_reg <= level_next;
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("queue popped while empty");

endmodule

// ===== sv/bpr_back.sv =====
// ----------------------------------------------------------------------------
// bpr_back
// Executes queued operations on the ring store and holds the result.
// ----------------------------------------------------------------------------
module bpr_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bpr_pkg::bpr_op_t             head_op,
    input  bpr_pkg::bpr_qstat_t          qstat,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bpr_pkg::BYTE_W-1:0]   data_out,
    output logic [2:0]                   status,
    output logic [bpr_pkg::FILL_W-1:0]   fill_level
);
    import bpr_pkg::*;

    logic              out_valid_reg;
    status_t           status_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              rd_sel_reg;
    logic [BYTE_W-1:0] ram_rdata;
    logic              ram_we;
    logic              ram_re;

    // Result slot frees when empty or taken this cycle
    assign pop    = !qstat.empty && (!out_valid_reg || !out_stall);
    assign ram_we = pop && (head_op.kind == KIND_WRITE);
    assign ram_re = pop && (head_op.kind == KIND_READ);

    bpr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_op.addr),
        .wdata (head_op.data),
        .re    (ram_re),
        .raddr (head_op.addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= head_op.status;
            fill_reg   <= head_op.fill;
            rd_sel_reg <= (head_op.kind == KIND_READ);
        end
    end

    // RAM read data only moves on a pop, so it holds through a stall
    assign out_valid  = out_valid_reg;
    assign data_out   = rd_sel_reg ? ram_rdata : '0;
    assign status     = status_reg;
    assign fill_level = fill_reg;

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !pop)
        else $error("result overwritten while stalled");

endmodule
